>>> sv/midi_serial_byte_parser_defines.svh
// assertion macros shared by the parser rtl files
// no dependencies; included by the files that carry assertions
`ifndef MIDI_SERIAL_BYTE_PARSER_DEFINES_SVH
`define MIDI_SERIAL_BYTE_PARSER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SBP_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("midi parser assertion failed");

// next-cycle implication, checked outside reset
`define SBP_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("midi parser assertion failed");

`endif

>>> sv/midi_sbp_pkg.sv
// shared types, codes and length tables of the midi byte parser
// no dependencies; used by the parse, output buffer and top-level rtl files
package midi_sbp_pkg;

	localparam int RING_DEPTH = 8;
	localparam int SLOT_W     = $clog2(RING_DEPTH);
	localparam int RING_W     = 72;
	localparam int CFG_IDX_W  = 2;
	localparam int WCNT_W     = 32;

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);
	localparam logic [WCNT_W-1:0] WCNT_MAX  = '1;

	// result destinations
	localparam logic [2:0] DEST_NONE     = 3'd0;
	localparam logic [2:0] DEST_PRIMARY  = 3'd1;
	localparam logic [2:0] DEST_REALTIME = 3'd2;
	localparam logic [2:0] DEST_RAW      = 3'd3;
	localparam logic [2:0] DEST_SYSEX    = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PORT_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BYPASS_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAW_FORWARD = 2'd2;

	// status bytes with special handling
	localparam logic [7:0] ST_CHAN_MAX    = 8'hef;
	localparam logic [7:0] ST_SYSEX_START = 8'hf0;
	localparam logic [7:0] ST_EOX         = 8'hf7;
	localparam logic [7:0] ST_CLOCK       = 8'hf8;
	localparam logic [7:0] ST_START       = 8'hfa;
	localparam logic [7:0] ST_CONTINUE    = 8'hfb;
	localparam logic [7:0] ST_STOP        = 8'hfc;
	localparam logic [7:0] ST_SENSING     = 8'hfe;

	// message lengths by status nibble / system-common low bits
	localparam logic [1:0] CHAN_LEN [8] = '{2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3};
	localparam logic [1:0] SYS_LEN  [8] = '{2'd0, 2'd2, 2'd3, 2'd2, 2'd0, 2'd0, 2'd1, 2'd1};

	typedef struct packed {
		logic port_enable;
		logic bypass_mode;
		logic raw_forward_enable;
	} cfg_t;

	typedef struct packed {
		logic [2:0] destination;
		logic [1:0] msg_length;
		logic [7:0] msg_byte0;
		logic [6:0] msg_byte1;
		logic [6:0] msg_byte2;
		logic       sensing_seen;
		logic       ring_pushed;
		logic [2:0] ring_slot;
	} result_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] addr;
		logic [RING_W-1:0] data;
	} ring_wr_t;

	function automatic logic [1:0] msg_len(input logic [7:0] s);
		logic [1:0] len;
		if (s <= ST_CHAN_MAX)
			len = CHAN_LEN[s[6:4]];
		else if (s <= ST_EOX)
			len = SYS_LEN[s[2:0]];
		else
			len = 2'd1;
		return len;
	endfunction

endpackage

>>> sv/midi_sbp_ram.sv
// generic single-port-write ram with registered read
// no dependencies
module midi_sbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end

endmodule

>>> sv/midi_sbp_parse.sv
// byte classifier and message assembler with running status and ring pointer
// depends on midi_sbp_pkg and midi_serial_byte_parser_defines.svh
`include "midi_serial_byte_parser_defines.svh"

module midi_sbp_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  midi_sbp_pkg::cfg_t   cfg,
	input  logic                 accept,
	input  logic [7:0]           rx_byte,
	input  logic                 downstream_busy,
	input  logic                 realtime_queue_full,
	input  logic [63:0]          time_now,
	output midi_sbp_pkg::result_t  res,
	output midi_sbp_pkg::ring_wr_t ring_wr
);

	logic [7:0]                        rs_q, rs_d;
	logic [1:0]                        cnt_q, cnt_d;
	logic [6:0]                        d0_q, d0_d;
	logic [6:0]                        d1_q, d1_d;
	logic                              sysex_q, sysex_d;
	logic                              sense_q, sense_d;
	logic [midi_sbp_pkg::WCNT_W-1:0]   wcnt_q, wcnt_d;
	logic [midi_sbp_pkg::SLOT_W-1:0]   slot_q, slot_d;
	logic [1:0]                        exp_cur;
	logic [1:0]                        exp_new;
	logic [1:0]                        cnt_inc;

	always_comb begin
		rs_d    = rs_q;
		cnt_d   = cnt_q;
		d0_d    = d0_q;
		d1_d    = d1_q;
		sysex_d = sysex_q;
		sense_d = sense_q;
		wcnt_d  = wcnt_q;
		slot_d  = slot_q;
		res     = '0;
		ring_wr.we   = 1'b0;
		ring_wr.addr = slot_q;
		ring_wr.data = {rx_byte, time_now};
		exp_cur = midi_sbp_pkg::msg_len(rs_q);
		exp_new = midi_sbp_pkg::msg_len(rx_byte);
		cnt_inc = cnt_q + 2'd1;

		if (cfg.port_enable && cfg.bypass_mode) begin
			if (cfg.raw_forward_enable) begin
				res.destination = midi_sbp_pkg::DEST_RAW;
				res.msg_length  = 2'd1;
				res.msg_byte0   = rx_byte;
			end
		end else if (cfg.port_enable) begin
			if (rx_byte[7]) begin
				if (rx_byte > midi_sbp_pkg::ST_EOX) begin
					if (rx_byte == midi_sbp_pkg::ST_SENSING) begin
						sense_d = 1'b1;
					end else if (rx_byte inside {midi_sbp_pkg::ST_CLOCK,
							midi_sbp_pkg::ST_START, midi_sbp_pkg::ST_CONTINUE,
							midi_sbp_pkg::ST_STOP}) begin
						ring_wr.we      = 1'b1;
						wcnt_d          = wcnt_q + 1'b1;
						// the 32-bit write count wraps to slot zero as well
						if (wcnt_q == midi_sbp_pkg::WCNT_MAX || slot_q == midi_sbp_pkg::SLOT_LAST)
							slot_d = '0;
						else
							slot_d = slot_q + 1'b1;
						res.ring_pushed = 1'b1;
						res.ring_slot   = 3'(slot_q);
						if (!downstream_busy && !realtime_queue_full) begin
							res.destination = midi_sbp_pkg::DEST_REALTIME;
							res.msg_length  = 2'd1;
							res.msg_byte0   = rx_byte;
						end
					end
				end else if (rx_byte == midi_sbp_pkg::ST_SYSEX_START) begin
					sysex_d = 1'b1;
					cnt_d   = 2'd0;
					if (!downstream_busy) begin
						res.destination = midi_sbp_pkg::DEST_SYSEX;
						res.msg_length  = 2'd1;
						res.msg_byte0   = rx_byte;
					end
				end else if (rx_byte == midi_sbp_pkg::ST_EOX) begin
					if (sysex_q && !downstream_busy) begin
						res.destination = midi_sbp_pkg::DEST_SYSEX;
						res.msg_length  = 2'd1;
						res.msg_byte0   = rx_byte;
					end
					sysex_d = 1'b0;
					cnt_d   = 2'd0;
				end else begin
					sysex_d = 1'b0;
					rs_d    = rx_byte;
					cnt_d   = 2'd1;
					// single-byte system common completes at once
					if (exp_new == 2'd1) begin
						cnt_d = 2'd0;
						if (!downstream_busy) begin
							res.destination = midi_sbp_pkg::DEST_REALTIME;
							res.msg_length  = 2'd1;
							res.msg_byte0   = rx_byte;
						end
					end
				end
			end else if (sysex_q) begin
				if (!downstream_busy) begin
					res.destination = midi_sbp_pkg::DEST_SYSEX;
					res.msg_length  = 2'd1;
					res.msg_byte0   = rx_byte;
				end
			end else if (cnt_q != 2'd0 && cnt_q < exp_cur) begin
				if (cnt_q == 2'd1)
					d0_d = rx_byte[6:0];
				else
					d1_d = rx_byte[6:0];
				cnt_d = cnt_inc;
				if (cnt_inc == exp_cur) begin
					if (rs_q <= midi_sbp_pkg::ST_CHAN_MAX)
						cnt_d = 2'd1;
					else
						cnt_d = 2'd0;
					if (!downstream_busy) begin
						res.destination = (rs_q <= midi_sbp_pkg::ST_CHAN_MAX) ?
							midi_sbp_pkg::DEST_PRIMARY : midi_sbp_pkg::DEST_REALTIME;
						res.msg_length  = exp_cur;
						res.msg_byte0   = rs_q;
						res.msg_byte1   = d0_d;
						res.msg_byte2   = (exp_cur == 2'd3) ? d1_d : 7'd0;
					end
				end
			end
		end
		res.sensing_seen = sense_d;
		if (!accept)
			ring_wr.we = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q    <= '0;
			cnt_q   <= '0;
			sysex_q <= 1'b0;
			sense_q <= 1'b0;
			wcnt_q  <= '0;
			slot_q  <= '0;
		end else if (accept) begin
			rs_q    <= rs_d;
			cnt_q   <= cnt_d;
			sysex_q <= sysex_d;
			sense_q <= sense_d;
			wcnt_q  <= wcnt_d;
			slot_q  <= slot_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			d0_q <= d0_d;
			d1_q <= d1_d;
		end
	end

	// a count of three always completes the message in the same transaction
	`SBP_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q != 2'd3)
	`SBP_ASSERT_NXT(a_idle_hold, clk, arst_n, !accept, $stable({rs_q, cnt_q, sysex_q, wcnt_q, slot_q}))
	`SBP_ASSERT_IMP(a_slot_range, clk, arst_n, 1'b1, slot_q <= midi_sbp_pkg::SLOT_LAST)

endmodule

>>> sv/midi_sbp_outbuf.sv
// two-entry output buffer: result register plus skid entry
// depends on midi_sbp_pkg and midi_serial_byte_parser_defines.svh
`include "midi_serial_byte_parser_defines.svh"

module midi_sbp_outbuf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  midi_sbp_pkg::result_t push_data,
	input  logic                  out_stall,
	output logic                  out_valid,
	output midi_sbp_pkg::result_t out_data,
	output logic                  full
);

	logic                  main_valid_q;
	logic                  skid_valid_q;
	midi_sbp_pkg::result_t main_q;
	midi_sbp_pkg::result_t skid_q;
	logic                  pop;

	assign pop       = main_valid_q && !out_stall;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;
	assign full      = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop)
				skid_valid_q <= 1'b0;
		end else if (push) begin
			if (!main_valid_q || pop)
				main_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop)
				main_q <= skid_q;
		end else if (push) begin
			if (!main_valid_q || pop)
				main_q <= push_data;
			else
				skid_q <= push_data;
		end
	end

	`SBP_ASSERT_IMP(a_skid_behind_main, clk, arst_n, skid_valid_q, main_valid_q)
	`SBP_ASSERT_NXT(a_skid_drain, clk, arst_n, skid_valid_q && !out_stall, main_valid_q && !skid_valid_q)

endmodule

>>> sv/midi_serial_byte_parser.sv
// top level of the midi serial byte parser
// depends on midi_sbp_pkg, midi_sbp_ram, midi_sbp_parse, midi_sbp_outbuf
//
// input channel: one received byte per transaction (in_valid / in_stall) with the
// downstream busy and realtime full flags and the arrival timestamp.
// output channel: exactly one result per input byte (out_valid / out_stall),
// carrying destination, assembled message bytes, sensing flag and ring slot.
// each result is registered in the output buffer before it is presented.
// throughput: one byte per cycle while the output buffer is not full; the whole
// parser context updates in the cycle the byte is taken, so consecutive bytes need no spacing.
// the clock-event ring is an 8-entry ram written in the accepting cycle.
// when the receiver stalls, results queue in a two-entry output buffer; the
// input stalls only once both entries hold results.
// configuration: write enable, index and data; write only while idle.
// reset clears running status, message count, sysex and sensing flags, the
// ring write count and the output buffer; ring contents stay undefined.
`include "midi_serial_byte_parser_defines.svh"

module midi_serial_byte_parser (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [midi_sbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic                                cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          rx_byte,
	input  logic                                downstream_busy,
	input  logic                                realtime_queue_full,
	input  logic [63:0]                         time_now,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [2:0]                          destination,
	output logic [1:0]                          msg_length,
	output logic [7:0]                          msg_byte0,
	output logic [6:0]                          msg_byte1,
	output logic [6:0]                          msg_byte2,
	output logic                                sensing_seen,
	output logic                                ring_pushed,
	output logic [2:0]                          ring_slot
);

	midi_sbp_pkg::cfg_t              cfg_q;
	midi_sbp_pkg::result_t           res;
	midi_sbp_pkg::result_t           out_data;
	midi_sbp_pkg::ring_wr_t          ring_wr;
	logic                            accept;
	logic                            buf_full;
	logic [midi_sbp_pkg::SLOT_W-1:0] ring_rd_addr_q;
	logic [midi_sbp_pkg::RING_W-1:0] ring_rd_data;

	assign in_stall = buf_full;
	assign accept   = in_valid && !buf_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				midi_sbp_pkg::CFG_PORT_ENABLE: cfg_q.port_enable        <= cfg_data;
				midi_sbp_pkg::CFG_BYPASS_MODE: cfg_q.bypass_mode        <= cfg_data;
				midi_sbp_pkg::CFG_RAW_FORWARD: cfg_q.raw_forward_enable <= cfg_data;
				default: ;
			endcase
		end
	end

	midi_sbp_parse u_parse (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg                 (cfg_q),
		.accept              (accept),
		.rx_byte             (rx_byte),
		.downstream_busy     (downstream_busy),
		.realtime_queue_full (realtime_queue_full),
		.time_now            (time_now),
		.res                 (res),
		.ring_wr             (ring_wr)
	);

	// read port follows the last written slot
	always_ff @(posedge clk) begin
		if (ring_wr.we)
			ring_rd_addr_q <= ring_wr.addr;
	end

	midi_sbp_ram #(
		.WIDTH (midi_sbp_pkg::RING_W),
		.DEPTH (midi_sbp_pkg::RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.we      (ring_wr.we),
		.wr_addr (ring_wr.addr),
		.wr_data (ring_wr.data),
		.rd_addr (ring_rd_addr_q),
		.rd_data (ring_rd_data)
	);

	midi_sbp_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.full      (buf_full)
	);

	assign destination  = out_data.destination;
	assign msg_length   = out_data.msg_length;
	assign msg_byte0    = out_data.msg_byte0;
	assign msg_byte1    = out_data.msg_byte1;
	assign msg_byte2    = out_data.msg_byte2;
	assign sensing_seen = out_data.sensing_seen;
	assign ring_pushed  = out_data.ring_pushed;
	assign ring_slot    = out_data.ring_slot;

	// a stamped clock event reads back from the ring through the read-address register and the registered ram read
	`SBP_ASSERT_IMP(a_ring_readback, clk, arst_n, ring_wr.we, ##2 (ring_rd_data == $past(ring_wr.data, 2)))

endmodule
